// ===== rtl/pca_pkg.sv =====
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types and constants for the packed counter array.
// ----------------------------------------------------------------------------
`default_nettype none

package pca_pkg;

    localparam int WORD_BITS            = 32;
    localparam int DEF_STORE_WORDS      = 1024;
    localparam int DEF_MAX_COUNTER_BITS = 32;

    localparam logic [5:0] CFG_WIDTH_RESET = 6'd4;

    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_DEC  = 2'd1;
    localparam logic [1:0] KIND_SET  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [14:0] counter_index;
    } t_in_word;

    typedef struct packed {
        logic [31:0] counter_value;
        logic        is_nonzero;
        logic        index_error;
    } t_out_word;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] off;
        logic [5:0] width;
    } t_field_ctl;

endpackage

`default_nettype wire

// ===== rtl/packed_counter_array.sv =====
// a read steps from accept through CALC, CHK, RD0, RD1, RD2 and EXEC to OUT; a
// decrement or set also passes WR0 and WR1 (two words read and written back
// through the single memory port, the second word only if it exists), and an
// out-of-range index goes from CHK straight to OUT; one word in flight, so the
// next word is taken only after OUT, later while the result is stalled; after
// reset a clearing pass zeroes the store with input stalled; width resets to 4
// ----------------------------------------------------------------------------
// packed_counter_array
// Saturating counters of configurable width packed into 32-bit words,
// with a small sequencer around one memory port and one shift unit.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_counter_array
    import pca_pkg::*;
#(
    parameter int STORE_WORDS      = DEF_STORE_WORDS,
    parameter int MAX_COUNTER_BITS = DEF_MAX_COUNTER_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [5:0] i_cfg_wdata,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    localparam int ADDR_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam logic [21:0] CAP_BITS  = 22'(STORE_WORDS * WORD_BITS);
    localparam logic [16:0] WORDS_N   = 17'(STORE_WORDS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_WORDS - 1);
    localparam logic [5:0]  MAX_W     = 6'(MAX_COUNTER_BITS);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CALC  = 4'd2;
    localparam logic [3:0] ST_CHK   = 4'd3;
    localparam logic [3:0] ST_RD0   = 4'd4;
    localparam logic [3:0] ST_RD1   = 4'd5;
    localparam logic [3:0] ST_RD2   = 4'd6;
    localparam logic [3:0] ST_EXEC  = 4'd7;
    localparam logic [3:0] ST_WR0   = 4'd8;
    localparam logic [3:0] ST_WR1   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [5:0]        r_cfg_width;
    logic [1:0]        r_kind;
    logic [14:0]       r_idx;
    logic [5:0]        r_w;
    logic [20:0]       r_s;
    logic              r_err;
    logic              r_has_next;
    logic [ADDR_W-1:0] r_wi;
    logic [4:0]        r_off;
    logic [63:0]       r_win;
    logic [31:0]       r_val;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic [5:0]        eff_w;
    logic              modify;
    logic              out_free;
    logic [21:0]       end_bit;
    logic [16:0]       next_wi;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [31:0]       mem_wdata;
    logic [31:0]       mem_rdata;
    t_field_ctl        fctl;
    logic [31:0]       f_value;
    logic [63:0]       f_window;

    always_comb begin
        if (r_cfg_width == 6'd0) begin
            eff_w = 6'd1;
        end else if (r_cfg_width > MAX_W) begin
            eff_w = MAX_W;
        end else begin
            eff_w = r_cfg_width;
        end
    end

    assign modify   = r_kind inside {KIND_DEC, KIND_SET};
    assign out_free = !r_out_valid || !i_out_stall;
    assign end_bit  = {1'b0, r_s} + {16'd0, r_w};
    assign next_wi  = {1'b0, r_s[20:5]} + 17'd1;

    assign fctl.kind  = r_kind;
    assign fctl.off   = r_off;
    assign fctl.width = r_w;

    pca_field u_field (
        .i_window (r_win),
        .i_ctl    (fctl),
        .o_value  (f_value),
        .o_window (f_window)
    );

    pca_mem #(
        .DEPTH  (STORE_WORDS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_wi;
        mem_wdata = r_win[63:32];
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_addr;
                mem_wdata = '0;
            end
            ST_RD1: begin
                mem_addr = r_wi + ADDR_W'(1);
            end
            ST_WR0: begin
                mem_we = 1'b1;
            end
            ST_WR1: begin
                mem_we    = r_has_next;
                mem_addr  = r_wi + ADDR_W'(1);
                mem_wdata = r_win[31:0];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: n_state = ST_CHK;
            ST_CHK:  n_state = (end_bit > CAP_BITS) ? ST_OUT : ST_RD0;
            ST_RD0:  n_state = ST_RD1;
            ST_RD1:  n_state = ST_RD2;
            ST_RD2:  n_state = ST_EXEC;
            ST_EXEC: n_state = modify ? ST_WR0 : ST_OUT;
            ST_WR0:  n_state = ST_WR1;
            ST_WR1:  n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_cfg_width <= CFG_WIDTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (i_cfg_we) begin
                r_cfg_width <= i_cfg_wdata;
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_kind <= i_in_word.kind;
                r_idx  <= i_in_word.counter_index;
                r_w    <= eff_w;
            end
            ST_CALC: begin
                r_s <= {6'd0, r_idx} * {15'd0, r_w};
            end
            ST_CHK: begin
                r_err      <= end_bit > CAP_BITS;
                r_wi       <= r_s[ADDR_W+4:5];
                r_off      <= r_s[4:0];
                r_has_next <= next_wi < WORDS_N;
            end
            ST_RD1: begin
                r_win[63:32] <= mem_rdata;
            end
            ST_RD2: begin
                r_win[31:0] <= r_has_next ? mem_rdata : 32'd0;
            end
            ST_EXEC: begin
                r_val <= f_value;
                r_win <= f_window;
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out_word.counter_value <= r_err ? 32'd0 : r_val;
                    r_out_word.is_nonzero    <= !r_err && (r_val != 32'd0);
                    r_out_word.index_error   <= r_err;
                end
            end
            default: begin
                r_kind <= r_kind;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // checks
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.index_error) |->
            (o_out_word.counter_value == 32'd0 && !o_out_word.is_nonzero))
        else $error("error word carries a value");

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.is_nonzero == (o_out_word.counter_value != 32'd0)))
        else $error("nonzero flag disagrees with value");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("word loaded outside output state");

    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> (r_state == ST_CLEAR || r_state == ST_IDLE))
        else $error("clearing pass left early");

    a_wr_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != ST_CLEAR) |-> modify)
        else $error("store written by a read");

endmodule

`default_nettype wire

// ===== rtl/pca_mem.sv =====
// ----------------------------------------------------------------------------
// pca_mem
// Single-port word store with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_mem
    import pca_pkg::*;
#(
    parameter int DEPTH  = DEF_STORE_WORDS,
    parameter int ADDR_W = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_W-1:0]    i_addr,
    input  wire logic [WORD_BITS-1:0] i_wdata,
    output logic      [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/pca_field.sv =====
// ----------------------------------------------------------------------------
// pca_field
// Shift and merge unit: extracts one counter from a two-word window,
// applies the operation and merges the new value back into the window.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_field
    import pca_pkg::*;
(
    input  wire logic [63:0]      i_window,
    input  wire t_field_ctl       i_ctl,
    output logic      [31:0]      o_value,
    output logic      [63:0]      o_window
);

    logic [6:0]  sh;
    logic [63:0] mask;
    logic [63:0] val;
    logic [63:0] nval;

    always_comb begin
        sh   = 7'd64 - {2'd0, i_ctl.off} - {1'b0, i_ctl.width};
        mask = (64'd1 << i_ctl.width) - 64'd1;
        val  = (i_window >> sh) & mask;
        case (i_ctl.kind)
            KIND_DEC: nval = (val != 64'd0) ? (val - 64'd1) : val;
            KIND_SET: nval = mask;
            default:  nval = val;
        endcase
        o_value  = nval[31:0];
        o_window = (i_window & ~(mask << sh)) | (nval << sh);
    end

endmodule

`default_nettype wire

// ===== tb/tb_packed_counter_array.sv =====
// ----------------------------------------------------------------------------
// tb_packed_counter_array
// Drives read, decrement and set-to-max words into the packed counter array
// across many counter widths. A behavioral copy of the packed word store
// predicts every result word, and the monitor compares it field by field.
// Covers straddling counters, out-of-range indexes and width changes over
// live data, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_packed_counter_array
    import pca_pkg::*;
;

    localparam int STORE_WORDS   = DEF_STORE_WORDS;
    localparam int MAX_BITS      = DEF_MAX_COUNTER_BITS;
    localparam int STORE_BITS    = STORE_WORDS * WORD_BITS;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 136;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [5:0] i_cfg_wdata = '0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_word   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;

    logic [31:0] model_words [STORE_WORDS];
    logic [5:0]  model_width_reg = CFG_WIDTH_RESET;
    t_out_word   expected_q [$];
    t_in_word    pending_q [$];

    int unsigned send_idle_pct    = 0;
    int unsigned recv_idle_pct    = 0;
    bit          in_taken         = 1'b0;
    int unsigned words_sent       = 0;
    int unsigned results_checked  = 0;
    int unsigned index_errors     = 0;
    int unsigned fail_count       = 0;
    int unsigned widths_used      = 1;
    int unsigned cycle_count      = 0;

    packed_counter_array #(
        .STORE_WORDS      (STORE_WORDS),
        .MAX_COUNTER_BITS (MAX_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned effective_width(input logic [5:0] code);
        int unsigned wd;
        wd = (code == 6'd0) ? 1 : code;
        if (wd > MAX_BITS) begin
            wd = MAX_BITS;
        end
        return wd;
    endfunction

    function automatic t_out_word apply_counter_op(input t_in_word item);
        int unsigned wd;
        int unsigned bit_pos;
        int unsigned wi;
        int unsigned sh;
        bit          has_next;
        logic [63:0] msk;
        logic [63:0] win;
        logic [63:0] val;
        t_out_word   res;
        wd      = effective_width(model_width_reg);
        msk     = (wd >= 32) ? 64'hFFFF_FFFF : ((64'd1 << wd) - 64'd1);
        bit_pos = item.counter_index * wd;
        res     = '0;
        if (bit_pos + wd > STORE_BITS) begin
            res.index_error = 1'b1;
            return res;
        end
        wi       = bit_pos >> 5;
        has_next = (wi + 1) < STORE_WORDS;
        win      = {model_words[wi], has_next ? model_words[wi + 1] : 32'd0};
        sh       = 64 - (bit_pos & 31) - wd;
        val      = (win >> sh) & msk;
        case (item.kind)
            KIND_DEC: begin
                if (val != 0) begin
                    val = val - 64'd1;
                end
            end
            KIND_SET: val = msk;
            default: ;
        endcase
        if (item.kind == KIND_DEC || item.kind == KIND_SET) begin
            win = (win & ~(msk << sh)) | (val << sh);
            model_words[wi] = win[63:32];
            if (has_next) begin
                model_words[wi + 1] = win[31:0];
            end
        end
        res.counter_value = val[31:0];
        res.is_nonzero    = (val != 0);
        return res;
    endfunction

    function automatic void queue_item(input logic [1:0] kind, input int unsigned idx);
        t_in_word w;
        w.kind          = kind;
        w.counter_index = idx[14:0];
        pending_q.push_back(w);
    endfunction

    task automatic wait_until_drained();
        do @(posedge i_clk);
        while (pending_q.size() != 0 || i_in_valid || expected_q.size() != 0);
    endtask

    task automatic write_width(input logic [5:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        widths_used++;
    endtask

    task automatic run_random_phase(input logic [5:0] width_code, input int unsigned n_items);
        int unsigned n_ctr;
        int unsigned hot_base;
        int unsigned sel;
        int unsigned idx;
        int unsigned beyond;
        logic [1:0]  kind;
        write_width(width_code);
        n_ctr    = STORE_BITS / effective_width(width_code);
        hot_base = $urandom_range(0, n_ctr - 16);
        for (int n = 0; n < n_items; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                idx = hot_base + $urandom_range(0, 15);
            end else if (sel < 65) begin
                idx = $urandom_range(0, n_ctr - 1);
            end else if (sel < 78) begin
                idx = n_ctr - 1 - $urandom_range(0, 3);
            end else if (sel < 88) begin
                beyond = n_ctr + $urandom_range(0, 3);
                idx    = (beyond > 32767) ? 32767 : beyond;
            end else begin
                idx = $urandom_range(0, 32767);
            end
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                kind = KIND_READ;
            end else if (sel < 70) begin
                kind = KIND_DEC;
            end else if (sel < 92) begin
                kind = KIND_SET;
            end else begin
                kind = KIND_UNUSED;
            end
            queue_item(kind, idx);
        end
        wait_until_drained();
    endtask

    // input driver and output stall
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            if (!i_in_valid || in_taken) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_word  <= pending_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: predict on accept, check on result
    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_WORDS; k++) begin
                model_words[k] = '0;
            end
            model_width_reg = CFG_WIDTH_RESET;
            in_taken        = 1'b0;
        end else begin
            if (i_cfg_we) begin
                model_width_reg = i_cfg_wdata;
            end
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) begin
                expected_q.push_back(apply_counter_op(i_in_word));
                words_sent++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result word with nothing expected, actual %h",
                             $time, o_out_word);
                end else begin
                    exp_word = expected_q.pop_front();
                    results_checked++;
                    if (o_out_word.index_error) begin
                        index_errors++;
                    end
                    if (o_out_word !== exp_word) begin
                        fail_count++;
                        if (o_out_word.counter_value !== exp_word.counter_value) begin
                            $display("%0t: counter_value expected %h actual %h", $time,
                                     exp_word.counter_value, o_out_word.counter_value);
                        end
                        if (o_out_word.is_nonzero !== exp_word.is_nonzero) begin
                            $display("%0t: is_nonzero expected %b actual %b", $time,
                                     exp_word.is_nonzero, o_out_word.is_nonzero);
                        end
                        if (o_out_word.index_error !== exp_word.index_error) begin
                            $display("%0t: index_error expected %b actual %b", $time,
                                     exp_word.index_error, o_out_word.index_error);
                        end
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached, %0d results still expected",
                 $time, expected_q.size());
        $display("tb_packed_counter_array: errors");
        $finish;
    end

    initial begin
        logic [5:0] phase_widths [RANDOM_PHASES];
        phase_widths = '{6'd1, 6'd32, 6'd5, 6'd0, 6'd13, 6'd31,
                         6'd63, 6'd8, 6'd3, 6'd33, 6'd17, 6'd2};
        phase_widths[RANDOM_PHASES - 1] = $urandom_range(0, 63);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 22;
        recv_idle_pct = 57;

        // reset width of four
        queue_item(KIND_SET, 0);
        queue_item(KIND_READ, 0);
        queue_item(KIND_DEC, 0);
        queue_item(KIND_DEC, 5);
        queue_item(KIND_UNUSED, 0);
        queue_item(KIND_SET, 8191);
        queue_item(KIND_READ, 8192);
        queue_item(KIND_SET, 32767);
        wait_until_drained();

        // width zero acts as one
        write_width(6'd0);
        queue_item(KIND_READ, 0);
        queue_item(KIND_DEC, 1);
        queue_item(KIND_SET, 32767);
        wait_until_drained();

        write_width(6'd32);
        queue_item(KIND_READ, 0);
        queue_item(KIND_SET, 1023);
        queue_item(KIND_DEC, 1023);
        queue_item(KIND_READ, 1024);
        wait_until_drained();

        // clamped to the maximum width
        write_width(6'd63);
        queue_item(KIND_READ, 1023);
        queue_item(KIND_DEC, 0);
        wait_until_drained();

        // straddling counters
        write_width(6'd5);
        queue_item(KIND_SET, 6);
        queue_item(KIND_DEC, 6);
        queue_item(KIND_READ, 7);
        queue_item(KIND_SET, 6552);
        queue_item(KIND_READ, 6553);
        wait_until_drained();

        write_width(6'd31);
        queue_item(KIND_SET, 1);
        queue_item(KIND_DEC, 1);
        queue_item(KIND_READ, 0);
        wait_until_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < RANDOM_PHASES / 3) begin
                send_idle_pct = 22;
                recv_idle_pct = 57;
            end else if (p < 2 * RANDOM_PHASES / 3) begin
                send_idle_pct = 57;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random_phase(phase_widths[p], PHASE_ITEMS);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            fail_count++;
            $display("%0t: %0d result words never arrived", $time, expected_q.size());
        end

        $display("run covered %0d words over %0d width settings", words_sent, widths_used);
        $display("%0d results checked, %0d of them out of range, %0d failures",
                 results_checked, index_errors, fail_count);
        if (fail_count == 0) begin
            $display("tb_packed_counter_array: clean");
        end else begin
            $display("tb_packed_counter_array: errors");
        end
        $finish;
    end

endmodule
